// ===== rtl/gamepad_input_conditioner_defines.svh =====
// Assertion macros for the gamepad input conditioner.
// No dependencies; included by the files that carry assertions.
`ifndef GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH

// Same-cycle implication, ignored while in reset
`define GIC_ASSERT_IMP(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("gic assertion failed");

// Next-cycle implication, ignored while in reset
`define GIC_ASSERT_NXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("gic assertion failed");

`endif

// ===== rtl/gic_pkg.sv =====
// Shared types and constants for the gamepad input conditioner.
// No dependencies; imported by every other RTL file but the assertion defines header.
package gic_pkg;

  localparam int BTN_W       = 16;
  localparam int AXIS_W      = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int NUM_BUTTONS_DEFAULT = 16;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HORIZ_GAIN     = 8'd0,
    REG_VERT_GAIN      = 8'd1,
    REG_SMOOTH_DIVISOR = 8'd2,
    REG_DOUBLE_WINDOW  = 8'd3
  } gic_reg_t;

  // Register reset values
  localparam logic [CFG_W-1:0] HORIZ_GAIN_RESET     = 8'd128;
  localparam logic [CFG_W-1:0] VERT_GAIN_RESET      = 8'd128;
  localparam logic [CFG_W-1:0] SMOOTH_DIVISOR_RESET = 8'd4;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET  = 8'd8;

  // Press timers
  localparam logic [7:0] TIMER_MAX   = 8'd255;
  localparam logic [7:0] TIMER_RESET = DOUBLE_WINDOW_RESET + 8'd1;

  // Stick arithmetic
  localparam logic [7:0]  GAIN_FLOOR = 8'd20;
  localparam logic [7:0]  GAIN_UNITY = 8'd128;
  localparam logic [13:0] P_LIMIT    = 14'd10240;
  localparam logic [6:0]  STICK_MAX  = 7'd127;

  // Divider: 16-bit dividend, 8-bit divisor, two quotient bits per cycle
  localparam int DIVD_W          = 16;
  localparam int DIV_BITS_PER_CY = 2;
  localparam int DIV_STEPS       = DIVD_W / DIV_BITS_PER_CY;

  // Status and result of one axis lane
  typedef struct packed {
    logic                     busy;
    logic signed [AXIS_W-1:0] stick;
    logic signed [AXIS_W-1:0] smooth;
  } gic_axis_res_t;

endpackage

// ===== rtl/gic_if.sv =====
// Channel interfaces: sample input, conditioned result output, register writes.
// Depends on gic_pkg.
interface gic_in_if import gic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BTN_W-1:0]         buttons;
  logic signed [AXIS_W-1:0] raw_x;
  logic signed [AXIS_W-1:0] raw_y;

  modport source (output valid, buttons, raw_x, raw_y, input ready);
  modport sink   (input valid, buttons, raw_x, raw_y, output ready);
endinterface

interface gic_out_if import gic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BTN_W-1:0]         held;
  logic [BTN_W-1:0]         released;
  logic [BTN_W-1:0]         pressed;
  logic [BTN_W-1:0]         double_press;
  logic [BTN_W-1:0]         double_hold;
  logic signed [AXIS_W-1:0] stick_x;
  logic signed [AXIS_W-1:0] stick_y;
  logic signed [AXIS_W-1:0] smooth_x;
  logic signed [AXIS_W-1:0] smooth_y;

  modport source (output valid, held, released, pressed, double_press, double_hold,
                  stick_x, stick_y, smooth_x, smooth_y, input ready);
  modport sink   (input valid, held, released, pressed, double_press, double_hold,
                  stick_x, stick_y, smooth_x, smooth_y, output ready);
endinterface

interface gic_cfg_if import gic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gic_divider.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on gic_pkg; used by gic_axis_lane.
module gic_divider import gic_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [7:0]        divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [7:0]        rem;
  logic [7:0]        den;
  logic [DIVD_W-1:0] quo;
  logic [7:0]        rem_next;
  logic [DIVD_W-1:0] quo_next;

  // Two shift-subtract steps; remainder stays below the divisor
  always_comb begin
    logic [8:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < DIV_BITS_PER_CY; k++) begin
      trial    = {rem_next, quo_next[DIVD_W-1]};
      quo_next = {quo_next[DIVD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next    = 8'(trial - {1'b0, den});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[7:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/gic_axis_lane.sv =====
// One stick axis lane: clamp, gain, limit, scale (shift or divide), then smoothing divide.
// Depends on gic_pkg and gic_divider.
module gic_axis_lane import gic_pkg::*; #(
  parameter bit VERTICAL = 1'b0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AXIS_W-1:0] raw,
  input  logic [CFG_W-1:0]         gain,
  input  logic [CFG_W-1:0]         divisor,
  output gic_axis_res_t            res
);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV1 = 5'b00100,
    A_SMUL = 5'b01000,
    A_DIV2 = 5'b10000
  } axis_state_t;

  axis_state_t state, state_next;

  logic                     sneg;
  logic [6:0]               smag;
  logic [7:0]               g_eff;
  logic [7:0]               dv;
  logic [7:0]               d_eff;
  logic                     nneg;
  logic signed [AXIS_W-1:0] stick;
  logic signed [AXIS_W-1:0] smoothed;

  logic [14:0]              prod;
  logic [13:0]              pclamp;
  logic [6:0]               p_shift;
  logic signed [AXIS_W-1:0] p_pos;
  logic signed [16:0]       sprod;
  logic signed [16:0]       sdiff;
  logic signed [16:0]       nsum;
  logic [16:0]              nmag;
  logic                     div_start;
  logic [DIVD_W-1:0]        div_num;
  logic [7:0]               div_den;
  logic                     div_done;
  logic [DIVD_W-1:0]        div_q;
  logic [6:0]               q_sat;
  logic signed [AXIS_W-1:0] q_pos;

  // Gained magnitude in units of 1/128, limited to 10240 (that is, 80)
  assign prod   = 15'(smag) * 15'(g_eff);
  assign pclamp = (prod > 15'(P_LIMIT)) ? P_LIMIT : prod[13:0];

  // Horizontal scale by 128 is a plain shift; at most 80
  assign p_shift = pclamp[13:7];
  assign p_pos   = $signed({1'b0, p_shift});

  // Smoothing numerator: old*d + (stick - old)
  assign sprod = $signed({{9{smoothed[7]}}, smoothed}) * $signed({9'd0, d_eff});
  assign sdiff = $signed({{9{stick[7]}}, stick}) - $signed({{9{smoothed[7]}}, smoothed});
  assign nsum  = sprod + sdiff;
  assign nmag  = nsum[16] ? 17'(-nsum) : 17'(nsum);

  // Shared divider feed
  assign div_start = ((state == A_MUL) && VERTICAL) || (state == A_SMUL);
  assign div_num   = (state == A_MUL) ? DIVD_W'(pclamp) : DIVD_W'(nmag[14:0]);
  assign div_den   = (state == A_MUL) ? dv : d_eff;

  gic_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturate quotient magnitude to 127
  assign q_sat = (div_q > DIVD_W'(STICK_MAX)) ? STICK_MAX : div_q[6:0];
  assign q_pos = $signed({1'b0, q_sat});

  // Sequencer; the horizontal lane skips the scale divide
  always_comb begin
    state_next = state;
    case (state)
      A_IDLE: if (start) state_next = A_MUL;
      A_MUL:  state_next = VERTICAL ? A_DIV1 : A_SMUL;
      A_DIV1: if (div_done) state_next = A_SMUL;
      A_SMUL: state_next = A_DIV2;
      A_DIV2: if (div_done) state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= A_IDLE;
      smoothed <= '0;
    end else begin
      state <= state_next;
      if (state == A_DIV2 && div_done) begin
        smoothed <= nneg ? -q_pos : q_pos;
      end
    end
  end

  // Operand capture and scaled stick result
  always_ff @(posedge clk) begin
    if (state == A_IDLE && start) begin
      sneg  <= raw[AXIS_W-1];
      smag  <= (raw == -8'sd128) ? STICK_MAX : 7'(raw[AXIS_W-1] ? -raw : raw);
      g_eff <= (gain < GAIN_FLOOR) ? GAIN_FLOOR : gain;
      if (VERTICAL) begin
        if (gain < GAIN_FLOOR) dv <= GAIN_FLOOR;
        else if (gain < GAIN_UNITY) dv <= gain;
        else dv <= GAIN_UNITY;
      end else begin
        dv <= GAIN_UNITY;
      end
      d_eff <= (divisor == '0) ? 8'd1 : divisor;
    end
    if (!VERTICAL && state == A_MUL) begin
      stick <= sneg ? -p_pos : p_pos;
    end
    if (state == A_DIV1 && div_done) begin
      stick <= sneg ? -q_pos : q_pos;
    end
    if (state == A_SMUL) begin
      nneg <= nsum[16];
    end
  end

  assign res.busy   = (state != A_IDLE);
  assign res.stick  = stick;
  assign res.smooth = smoothed;

endmodule

// ===== rtl/gic_button_lane.sv =====
// One button lane: saturating press timer and double press decision.
// Depends on gic_pkg.
module gic_button_lane import gic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             press,
  input  logic [CFG_W-1:0] window,
  output logic             dbl
);

  logic [7:0] timer;
  logic [7:0] win_p1;
  logic [7:0] timer_mid;

  assign win_p1 = (window == TIMER_MAX) ? TIMER_MAX : window + 8'd1;
  assign dbl    = press && (timer <= window);

  // Restart or rearm on a press, then count up without wrapping
  always_comb begin
    if (press) timer_mid = dbl ? win_p1 : 8'd0;
    else timer_mid = timer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= TIMER_RESET;
    end else if (step) begin
      timer <= (timer_mid == TIMER_MAX) ? TIMER_MAX : timer_mid + 8'd1;
    end
  end

endmodule

// ===== rtl/gamepad_input_conditioner.sv =====
// A sample is taken only while no sample is in flight: after a sample transfer the block waits
// until both axis lanes finish and the output register is free, then loads the result and is ready.
// The vertical lane sets the pace: scale divide, then smoothing divide, each a start,
// 8 steps at 2 bits per cycle and a done. A stalled result delays the next sample.
// Reset (synchronous): registers to their defaults, press timers to 9, history
// and smoothed sticks to zero, no result pending.
module gamepad_input_conditioner import gic_pkg::*; #(
  parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  gic_in_if.sink    sample,
  gic_out_if.source result,
  gic_cfg_if.sink   cfg
);

`include "gamepad_input_conditioner_defines.svh"

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_WAIT = 2'b10
  } top_state_t;

  top_state_t state;

  logic [CFG_W-1:0] horiz_gain;
  logic [CFG_W-1:0] vert_gain;
  logic [CFG_W-1:0] smooth_divisor;
  logic [CFG_W-1:0] double_window;

  logic [BTN_W-1:0] prev_held;
  logic [BTN_W-1:0] prev_double;
  logic [BTN_W-1:0] hold_mask;

  logic [BTN_W-1:0] pend_held;
  logic [BTN_W-1:0] pend_released;
  logic [BTN_W-1:0] pend_pressed;
  logic [BTN_W-1:0] pend_double;
  logic [BTN_W-1:0] pend_hold;

  logic             sample_xfer;
  logic             load;
  logic [BTN_W-1:0] pressed_now;
  logic [BTN_W-1:0] dbl_vec;
  logic [BTN_W-1:0] hold_next;
  gic_axis_res_t    lane_x;
  gic_axis_res_t    lane_y;

  assign sample.ready = (state == T_IDLE);
  assign sample_xfer  = sample.valid && sample.ready;
  assign cfg.ready    = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_gain     <= HORIZ_GAIN_RESET;
      vert_gain      <= VERT_GAIN_RESET;
      smooth_divisor <= SMOOTH_DIVISOR_RESET;
      double_window  <= DOUBLE_WINDOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HORIZ_GAIN:     horiz_gain     <= cfg.data;
        REG_VERT_GAIN:      vert_gain      <= cfg.data;
        REG_SMOOTH_DIVISOR: smooth_divisor <= cfg.data;
        REG_DOUBLE_WINDOW:  double_window  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Button lanes
  assign pressed_now = ~prev_held & sample.buttons;
  assign hold_next   = (hold_mask | prev_double) & sample.buttons;

  for (genvar i = 0; i < BTN_W; i++) begin : g_btn
    if (i < NUM_BUTTONS) begin : g_lane
      gic_button_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .step   (sample_xfer),
        .press  (pressed_now[i]),
        .window (double_window),
        .dbl    (dbl_vec[i])
      );
    end else begin : g_none
      assign dbl_vec[i] = 1'b0;
    end
  end

  // Axis lanes
  gic_axis_lane #(.VERTICAL(1'b0)) u_axis_x (
    .clk     (clk),
    .rst     (rst),
    .start   (sample_xfer),
    .raw     (sample.raw_x),
    .gain    (horiz_gain),
    .divisor (smooth_divisor),
    .res     (lane_x)
  );

  gic_axis_lane #(.VERTICAL(1'b1)) u_axis_y (
    .clk     (clk),
    .rst     (rst),
    .start   (sample_xfer),
    .raw     (sample.raw_y),
    .gain    (vert_gain),
    .divisor (smooth_divisor),
    .res     (lane_y)
  );

  // Button history, updated at each sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held   <= '0;
      prev_double <= '0;
      hold_mask   <= '0;
    end else if (sample_xfer) begin
      prev_held   <= sample.buttons;
      prev_double <= dbl_vec;
      hold_mask   <= hold_next;
    end
  end

  // Button results wait here for the axis lanes
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      pend_held     <= sample.buttons;
      pend_released <= prev_held & ~sample.buttons;
      pend_pressed  <= pressed_now;
      pend_double   <= dbl_vec;
      pend_hold     <= hold_next;
    end
  end

  // Merge: move a finished sample to the output register
  assign load = (state == T_WAIT) && !lane_x.busy && !lane_y.busy &&
                (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      result.valid <= 1'b0;
    end else begin
      case (state)
        T_IDLE:  if (sample_xfer) state <= T_WAIT;
        T_WAIT:  if (load) state <= T_IDLE;
        default: state <= T_IDLE;
      endcase
      if (load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.held         <= pend_held;
      result.released     <= pend_released;
      result.pressed      <= pend_pressed;
      result.double_press <= pend_double;
      result.double_hold  <= pend_hold;
      result.stick_x      <= lane_x.stick;
      result.stick_y      <= lane_y.stick;
      result.smooth_x     <= lane_x.smooth;
      result.smooth_y     <= lane_y.smooth;
    end
  end

  // Checks
  `GIC_ASSERT_NXT(a_xfer_waits, clk, rst, sample_xfer, state == T_WAIT)
  `GIC_ASSERT_IMP(a_lanes_in_wait, clk, rst, lane_x.busy || lane_y.busy, state == T_WAIT)
  `GIC_ASSERT_IMP(a_dbl_is_press, clk, rst, result.valid, (result.double_press & ~result.pressed) == '0)
  `GIC_ASSERT_IMP(a_hold_is_held, clk, rst, result.valid, (result.double_hold & ~result.held) == '0)

endmodule
